// ===== src/ckblit_pkg.sv =====
`default_nettype none

package ckblit_pkg;

    // Fixed field widths
    localparam int COORD_BITS = 12;
    localparam int ADDR_BITS  = 25;
    localparam int PIX_BITS   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GLYPH_HEIGHT  = 3'd0,
        CFG_GLYPH_WIDTH   = 3'd1,
        CFG_SCREEN_WIDTH  = 3'd2,
        CFG_SCREEN_HEIGHT = 3'd3,
        CFG_LINE_WORDS    = 3'd4
    } t_cfg_idx;

    // Reset values of the registers
    localparam logic [6:0]  RST_GLYPH_HEIGHT  = 7'd16;
    localparam logic [7:0]  RST_GLYPH_WIDTH   = 8'd16;
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [12:0] RST_LINE_WORDS    = 13'd640;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [6:0]  glyph_height;
        logic [7:0]  glyph_width;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [12:0] line_words;
    } t_cfg;

    // One visible, opaque write on its way to the address stage
    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [PIX_BITS-1:0]   pix;
    } t_wr;

    // RGB888 to RGB565 by truncation
    function automatic logic [PIX_BITS-1:0] to_565(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

// ===== src/colorkey_rgb565_glyph_blit_top.sv =====
// A written pixel passes the walk stage register, then the multiply stage register.
// Throughput: one item per clock; the walk stage and the multiply stage each
// hold one item and stall together when the output is not taken.
// Reset (i_rst_n low, synchronous): registers return to their defaults, no bitmap
// is active, and both stages are emptied.
`default_nettype none

module colorkey_rgb565_glyph_blit_top #(
    parameter int MAX_GLYPH_SIDE = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Pixel input
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    // tdata: origin_x[11:0], origin_y[23:12], red[31:24], green[39:32], blue[47:40]
    input  wire logic [47:0] i_s_axis_tdata,
    // tuser: first_pixel[0]
    input  wire logic        i_s_axis_tuser,
    // Framebuffer writes
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: word_address[24:0], pixel_565[40:25], zeros[47:41]
    output      logic [47:0] o_m_axis_tdata,
    // Configuration writes
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);
    import ckblit_pkg::*;

    t_cfg                 cfg;
    logic                 wr_valid, wr_ready;
    t_wr                  wr;
    logic [ADDR_BITS-1:0] word_address;
    logic [PIX_BITS-1:0]  pixel_565;

    assign o_cfg_ready = 1'b1;

    ckblit_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ckblit_walk #(
        .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_first    (i_s_axis_tuser),
        .i_origin_x (i_s_axis_tdata[11:0]),
        .i_origin_y (i_s_axis_tdata[23:12]),
        .i_red      (i_s_axis_tdata[31:24]),
        .i_green    (i_s_axis_tdata[39:32]),
        .i_blue     (i_s_axis_tdata[47:40]),
        .o_wr_valid (wr_valid),
        .i_wr_ready (wr_ready),
        .o_wr       (wr)
    );

    ckblit_addr u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_line_words   (cfg.line_words),
        .i_wr_valid     (wr_valid),
        .o_wr_ready     (wr_ready),
        .i_wr           (wr),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_word_address (word_address),
        .o_pixel_565    (pixel_565)
    );

    assign o_m_axis_tdata = {7'd0, pixel_565, word_address};

endmodule

`default_nettype wire

// ===== src/ckblit_cfg.sv =====
`default_nettype none

module ckblit_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [ckblit_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [ckblit_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output      ckblit_pkg::t_cfg                   o_cfg
);
    import ckblit_pkg::*;

    t_cfg r_cfg;

    // Register writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_height  <= RST_GLYPH_HEIGHT;
            r_cfg.glyph_width   <= RST_GLYPH_WIDTH;
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.line_words    <= RST_LINE_WORDS;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GLYPH_HEIGHT:  r_cfg.glyph_height  <= i_cfg_data[6:0];
                CFG_GLYPH_WIDTH:   r_cfg.glyph_width   <= i_cfg_data[7:0];
                CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[11:0];
                CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[11:0];
                CFG_LINE_WORDS:    r_cfg.line_words    <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/ckblit_walk.sv =====
`default_nettype none

module ckblit_walk #(
    parameter int MAX_GLYPH_SIDE = 128
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ckblit_pkg::t_cfg                   i_cfg,
    input  wire logic                               i_valid,
    output      logic                               o_ready,
    input  wire logic                               i_first,
    input  wire logic [ckblit_pkg::COORD_BITS-1:0]  i_origin_x,
    input  wire logic [ckblit_pkg::COORD_BITS-1:0]  i_origin_y,
    input  wire logic [7:0]                         i_red,
    input  wire logic [7:0]                         i_green,
    input  wire logic [7:0]                         i_blue,
    output      logic                               o_wr_valid,
    input  wire logic                               i_wr_ready,
    output      ckblit_pkg::t_wr                    o_wr
);
    import ckblit_pkg::*;

    localparam int CW = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;
    localparam int SW = $clog2(MAX_GLYPH_SIDE + 1);
    localparam int PW = COORD_BITS + 1;
    localparam logic [8:0] MAX_SIDE9 = 9'(MAX_GLYPH_SIDE);

    // Bitmap walk state
    logic [CW-1:0]         r_col, n_col;
    logic [CW-1:0]         r_row, n_row;
    logic [COORD_BITS-1:0] r_base_x, n_base_x;
    logic [COORD_BITS-1:0] r_base_y, n_base_y;
    logic                  r_done, n_done;

    // Stage register towards the address stage
    logic r_wr_valid;
    t_wr  r_wr;

    logic [SW-1:0]         w_side, h_side;
    logic [CW-1:0]         col_cur, row_cur;
    logic [SW-1:0]         col_inc, row_inc;
    logic [COORD_BITS-1:0] bx_cur, by_cur;
    logic [PW-1:0]         px, py;
    logic                  accept, active, visible, opaque;

    // Glyph sides, zero taken as one, clamped to the counter range
    always_comb begin
        if (i_cfg.glyph_width == 8'd0) begin
            w_side = SW'(1);
        end else if ({1'b0, i_cfg.glyph_width} > MAX_SIDE9) begin
            w_side = SW'(MAX_GLYPH_SIDE);
        end else begin
            w_side = SW'(i_cfg.glyph_width);
        end
        if (i_cfg.glyph_height == 7'd0) begin
            h_side = SW'(1);
        end else if ({2'b0, i_cfg.glyph_height} > MAX_SIDE9) begin
            h_side = SW'(MAX_GLYPH_SIDE);
        end else begin
            h_side = SW'(i_cfg.glyph_height);
        end
    end

    assign o_ready = !r_wr_valid || i_wr_ready;
    assign accept  = i_valid && o_ready;
    assign active  = i_first || !r_done;

    // Position of this item, a first item restarts at the new origin
    always_comb begin
        col_cur = i_first ? '0 : r_col;
        row_cur = i_first ? '0 : r_row;
        bx_cur  = i_first ? i_origin_x : r_base_x;
        by_cur  = i_first ? i_origin_y : r_base_y;
        px      = PW'(bx_cur) + PW'(col_cur);
        py      = PW'(by_cur) + PW'(row_cur);
        visible = (px < PW'(i_cfg.screen_width)) && (py < PW'(i_cfg.screen_height));
        opaque  = (i_red != 8'd0) || (i_green != 8'd0) || (i_blue != 8'd0);
        col_inc = SW'(col_cur) + SW'(1);
        row_inc = SW'(row_cur) + SW'(1);
    end

    // Counter advance, clipped pixels count too
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_base_x = r_base_x;
        n_base_y = r_base_y;
        n_done   = r_done;
        if (accept && active) begin
            n_base_x = bx_cur;
            n_base_y = by_cur;
            n_done   = 1'b0;
            if (col_inc >= w_side) begin
                n_col = '0;
                if (row_inc >= h_side) begin
                    n_row  = '0;
                    n_done = 1'b1;
                end else begin
                    n_row = CW'(row_inc);
                end
            end else begin
                n_col = CW'(col_inc);
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_base_x <= '0;
            r_base_y <= '0;
            r_done   <= 1'b1;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_base_x <= n_base_x;
            r_base_y <= n_base_y;
            r_done   <= n_done;
        end
    end

    // Stage register: only visible, opaque items of an active bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else if (o_ready) begin
            r_wr_valid <= accept && active && visible && opaque;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_wr.px  <= px[COORD_BITS-1:0];
            r_wr.py  <= py[COORD_BITS-1:0];
            r_wr.pix <= to_565(i_red, i_green, i_blue);
        end
    end

    assign o_wr_valid = r_wr_valid;
    assign o_wr       = r_wr;

endmodule

`default_nettype wire

// ===== src/ckblit_addr.sv =====
`default_nettype none

module ckblit_addr (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [12:0]                      i_line_words,
    input  wire logic                             i_wr_valid,
    output      logic                             o_wr_ready,
    input  wire ckblit_pkg::t_wr                  i_wr,
    output      logic                             o_valid,
    input  wire logic                             i_ready,
    output      logic [ckblit_pkg::ADDR_BITS-1:0] o_word_address,
    output      logic [ckblit_pkg::PIX_BITS-1:0]  o_pixel_565
);
    import ckblit_pkg::*;

    logic                 r_valid;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [PIX_BITS-1:0]  r_pix;
    logic [ADDR_BITS-1:0] prod;

    assign o_wr_ready = !r_valid || i_ready;

    // line * pitch + column, 12x13 product fits the address exactly
    always_comb begin
        prod   = {13'd0, i_wr.py} * {12'd0, i_line_words};
        n_addr = prod + {13'd0, i_wr.px};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_wr_ready) begin
            r_valid <= i_wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr_ready) begin
            r_addr <= n_addr;
            r_pix  <= i_wr.pix;
        end
    end

    assign o_valid        = r_valid;
    assign o_word_address = r_addr;
    assign o_pixel_565    = r_pix;

endmodule

`default_nettype wire

// ===== dv/colorkey_blit_checker.sv =====
// Watches the pixel, write and configuration channels of the glyph blitter,
// keeps its own copy of the register file and the bitmap walk, and checks
// every framebuffer write against the oldest predicted one.
module colorkey_blit_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel channel
    input  wire logic        i_pix_valid,
    input  wire logic        i_pix_ready,
    input  wire logic [47:0] i_pix_data,
    input  wire logic        i_pix_first,
    // framebuffer write channel
    input  wire logic        i_wr_valid,
    input  wire logic        i_wr_ready,
    input  wire logic [47:0] i_wr_data,
    // configuration channel
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_writes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ckblit_pkg::*;

    localparam int MAX_SIDE = 128;

    typedef struct packed {
        logic [24:0] addr;
        logic [15:0] rgb565;
    } fb_write_t;

    // shadow registers
    logic [6:0]  glyph_h;
    logic [7:0]  glyph_w;
    logic [11:0] scr_w;
    logic [11:0] scr_h;
    logic [12:0] pitch;

    // bitmap walk
    int unsigned walk_row;
    int unsigned walk_col;
    logic [11:0] org_x;
    logic [11:0] org_y;
    bit          glyph_done;

    fb_write_t   expected_writes[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] write check: %s", $time, what);
        fail_count++;
    endtask

    function automatic int unsigned side_limit(input int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    task automatic clear_model();
        glyph_h    = RST_GLYPH_HEIGHT;
        glyph_w    = RST_GLYPH_WIDTH;
        scr_w      = RST_SCREEN_WIDTH;
        scr_h      = RST_SCREEN_HEIGHT;
        pitch      = RST_LINE_WORDS;
        walk_row   = 0;
        walk_col   = 0;
        org_x      = '0;
        org_y      = '0;
        glyph_done = 1'b1;
        expected_writes.delete();
    endtask

    task automatic write_shadow(input logic [2:0] idx, input logic [12:0] value);
        case (idx)
            CFG_GLYPH_HEIGHT:  glyph_h = value[6:0];
            CFG_GLYPH_WIDTH:   glyph_w = value[7:0];
            CFG_SCREEN_WIDTH:  scr_w   = value[11:0];
            CFG_SCREEN_HEIGHT: scr_h   = value[11:0];
            CFG_LINE_WORDS:    pitch   = value;
            default: ;
        endcase
    endtask

    // Walk one pixel through the bitmap and queue the write it makes, if any
    task automatic predict_write(input logic first, input logic [47:0] data);
        int unsigned     w_eff;
        int unsigned     h_eff;
        longint unsigned px;
        longint unsigned py;
        logic [7:0]      r;
        logic [7:0]      g;
        logic [7:0]      b;
        fb_write_t       wr;
        r     = data[31:24];
        g     = data[39:32];
        b     = data[47:40];
        w_eff = side_limit(glyph_w);
        h_eff = side_limit(glyph_h);
        if (first) begin
            org_x      = data[11:0];
            org_y      = data[23:12];
            walk_row   = 0;
            walk_col   = 0;
            glyph_done = 1'b0;
        end else if (glyph_done) begin
            return;
        end
        px = org_x + walk_col;
        py = org_y + walk_row;
        // black is the colour key; clipped pixels still advance the walk
        if (px < scr_w && py < scr_h && (r | g | b) != 8'd0) begin
            wr.addr   = 25'(py * pitch + px);
            wr.rgb565 = {r[7:3], g[7:2], b[7:3]};
            expected_writes.push_back(wr);
        end
        walk_col++;
        if (walk_col >= w_eff) begin
            walk_col = 0;
            walk_row++;
            if (walk_row >= h_eff) begin
                walk_row   = 0;
                glyph_done = 1'b1;
            end
        end
    endtask

    task automatic check_write(input logic [47:0] data);
        fb_write_t want;
        if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write addr %0d pixel %h",
                                      data[24:0], data[40:25]));
            return;
        end
        want = expected_writes.pop_front();
        if (data[24:0] !== want.addr)
            report_mismatch($sformatf("address %0d, expected %0d", data[24:0], want.addr));
        if (data[40:25] !== want.rgb565)
            report_mismatch($sformatf("pixel %h, expected %h at addr %0d",
                                      data[40:25], want.rgb565, want.addr));
        if (data[47:41] !== 7'd0)
            report_mismatch($sformatf("padding bits %b not zero", data[47:41]));
    endtask

    // writes are checked before the pixel of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_wr_valid && i_wr_ready)
                check_write(i_wr_data);
            if (i_cfg_valid && i_cfg_ready)
                write_shadow(i_cfg_index, i_cfg_data);
            if (i_pix_valid && i_pix_ready)
                predict_write(i_pix_first, i_pix_data);
        end
        o_writes_pending <= expected_writes.size();
    end

endmodule

// ===== dv/tb_colorkey_rgb565_glyph_blit_top.sv =====
module tb_colorkey_rgb565_glyph_blit_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ckblit_pkg::*;

    localparam int MAX_SIDE = 128;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [47:0] s_data    = '0;
    logic        s_first   = 1'b0;
    logic        m_ready   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data  = '0;
    wire logic        s_ready;
    wire logic        m_valid;
    wire logic [47:0] m_data;
    wire logic        cfg_ready;

    int   fail_count;
    int   writes_pending;
    int   pixels_sent = 0;
    bit   gaps_on     = 1'b1;
    logic stalls_on   = 1'b1;
    logic hold_req    = 1'b0;

    always #1 clk = ~clk;

    colorkey_rgb565_glyph_blit_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_first),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    colorkey_blit_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_pix_valid      (s_valid),
        .i_pix_ready      (s_ready),
        .i_pix_data       (s_data),
        .i_pix_first      (s_first),
        .i_wr_valid       (m_valid),
        .i_wr_ready       (m_ready),
        .i_wr_data        (m_data),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_writes_pending (writes_pending)
    );

    // Sender idle time: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (!gaps_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // {red, green, blue}: transparent, dark, white or anything
    function automatic logic [23:0] pick_colour();
        case ($urandom_range(0, 9))
            0, 1:    return 24'h000000;
            2:       return {5'd0, 3'($urandom), 6'd0, 2'($urandom), 5'd0, 3'($urandom)};
            3:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic first, input logic [11:0] ox, input logic [11:0] oy,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        s_valid <= 1'b1;
        s_first <= first;
        s_data  <= {b, g, r, oy, ox};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write; the caller lowers valid after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [12:0] gh, input logic [12:0] gw,
                              input logic [12:0] sw, input logic [12:0] sh,
                              input logic [12:0] lw);
        write_reg(CFG_GLYPH_HEIGHT, gh);
        write_reg(CFG_GLYPH_WIDTH, gw);
        write_reg(CFG_SCREEN_WIDTH, sw);
        write_reg(CFG_SCREEN_HEIGHT, sh);
        write_reg(CFG_LINE_WORDS, lw);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every predicted write, then for the pipeline to empty
    task automatic drain_writes();
        s_valid <= 1'b0;
        @(posedge clk);
        while (writes_pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // One bitmap, sometimes cut short, sometimes followed by stray pixels
    task automatic send_bitmap(input int w_eff, input int h_eff, input int sw, input int sh);
        int          total;
        int          k;
        int          near_x;
        int          near_y;
        logic [11:0] ox;
        logic [11:0] oy;
        logic [23:0] rgb;
        total = w_eff * h_eff;
        if (total > 200 || $urandom_range(0, 9) == 0)
            total = $urandom_range(1, (total > 200) ? 200 : total);
        case ($urandom_range(0, 3))
            0: begin
                ox = 12'($urandom);
                oy = 12'($urandom);
            end
            1: begin
                // hug the right and bottom edges
                near_x = sw - int'($urandom_range(0, w_eff));
                near_y = sh - int'($urandom_range(0, h_eff));
                ox = 12'((near_x < 0) ? 0 : near_x);
                oy = 12'((near_y < 0) ? 0 : near_y);
            end
            default: begin
                ox = 12'($urandom_range(0, sw));
                oy = 12'($urandom_range(0, sh));
            end
        endcase
        for (k = 0; k < total; k++) begin
            rgb = pick_colour();
            if (k == 0)
                send_pixel(1'b1, ox, oy, rgb[23:16], rgb[15:8], rgb[7:0]);
            else
                send_pixel(1'b0, 12'($urandom), 12'($urandom), rgb[23:16], rgb[15:8], rgb[7:0]);
            pixels_sent++;
        end
        if (total == w_eff * h_eff && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                rgb = pick_colour();
                send_pixel(1'b0, 12'($urandom), 12'($urandom), rgb[23:16], rgb[15:8], rgb[7:0]);
            end
        end
    endtask

    // Random register setting, then at least 150 pixels of bitmaps
    task automatic run_random_phase(input bit pressure);
        int gh;
        int gw;
        int sw;
        int sh;
        int lw;
        int w_eff;
        int h_eff;
        int start;
        case ($urandom_range(0, 9))
            0:       gh = 0;
            1:       gh = 127;
            2:       gh = $urandom_range(7, 126);
            default: gh = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 9))
            0:       gw = 0;
            1:       gw = $urandom_range(128, 255);
            2:       gw = $urandom_range(9, 127);
            default: gw = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 19))
            0:          sw = 0;
            1, 2:       sw = 4095;
            3, 4, 5:    sw = $urandom_range(1, 4095);
            default:    sw = $urandom_range(1, 48);
        endcase
        case ($urandom_range(0, 19))
            0:          sh = 0;
            1, 2:       sh = 4095;
            3, 4, 5:    sh = $urandom_range(1, 4095);
            default:    sh = $urandom_range(1, 48);
        endcase
        case ($urandom_range(0, 9))
            0:       lw = 1;
            1:       lw = 8191;
            default: lw = $urandom_range(1, 8191);
        endcase
        // the back-pressure phase needs visible pixels to fill the pipe
        if (pressure) begin
            sw = 4095;
            sh = 4095;
        end
        set_config(13'(gh), 13'(gw), 13'(sw), 13'(sh), 13'(lw));
        w_eff = (gw == 0) ? 1 : ((gw > MAX_SIDE) ? MAX_SIDE : gw);
        h_eff = (gh == 0) ? 1 : ((gh > MAX_SIDE) ? MAX_SIDE : gh);
        gaps_on   = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
        stalls_on <= pressure ? 1'b1 : ($urandom_range(0, 3) != 0);
        if (pressure) hold_req <= 1'b1;
        start = pixels_sent;
        while (pixels_sent - start < 150) send_bitmap(w_eff, h_eff, sw, sh);
        drain_writes();
    endtask

    // Write receiver: random ready, plus one long hold-off on request
    initial begin : write_sink
        int  run_len;
        int  held_cycles;
        bit  held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < 300; held_cycles++) @(posedge clk);
                held = 1'b1;
            end else if (!stalls_on || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                run_len = $urandom_range(1, 12);
                repeat (run_len) @(posedge clk);
            end else begin
                m_ready <= 1'b0;
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
                repeat (run_len) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: 16x16 glyph on 640x480
        send_pixel(1'b0, 12'd5, 12'd5, 8'hFF, 8'hFF, 8'hFF);       // no bitmap yet: dropped
        send_pixel(1'b1, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(1'b0, 12'hFFF, 12'hFFF, 8'h00, 8'h00, 8'h00);   // colour key
        send_pixel(1'b0, 12'h000, 12'hFFF, 8'h07, 8'h03, 8'h07);   // dark, rounds to zero
        send_pixel(1'b0, 12'hFFF, 12'h000, 8'hF8, 8'h00, 8'h00);
        send_pixel(1'b0, 12'h0AA, 12'h555, 8'h00, 8'hFC, 8'h00);
        send_pixel(1'b0, 12'h555, 12'h0AA, 8'h00, 8'h00, 8'hF8);
        send_pixel(1'b1, 12'hFFF, 12'hFFF, 8'hFF, 8'h00, 8'hFF);   // wholly off screen
        send_pixel(1'b1, 12'd639, 12'd479, 8'h81, 8'h42, 8'h24);   // last visible pixel
        send_pixel(1'b0, 12'd0, 12'd0, 8'h81, 8'h42, 8'h24);       // clipped at right edge
        drain_writes();

        // zero glyph size acts as 1x1; largest screen and pitch
        set_config(13'd0, 13'd0, 13'd4095, 13'd4095, 13'd8191);
        send_pixel(1'b1, 12'd4094, 12'd4094, 8'hFF, 8'hFF, 8'hFF); // highest address
        send_pixel(1'b0, 12'd1, 12'd1, 8'hFF, 8'hFF, 8'hFF);       // beyond glyph
        send_pixel(1'b1, 12'd4095, 12'd0, 8'h10, 8'h20, 8'h30);    // clipped column
        send_pixel(1'b1, 12'd0, 12'd4095, 8'h10, 8'h20, 8'h30);    // clipped line
        send_pixel(1'b1, 12'd0, 12'd0, 8'h01, 8'h00, 8'h00);
        drain_writes();

        // zero screen clips all; oversized width
        set_config(13'd127, 13'd255, 13'd0, 13'd0, 13'd1);
        send_pixel(1'b1, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(1'b0, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF);
        drain_writes();

        // 3x2 glyph crossing both screen edges, then one pixel past its end
        set_config(13'd2, 13'd3, 13'd4, 13'd3, 13'd1);
        send_pixel(1'b1, 12'd2, 12'd2, 8'h11, 8'h22, 8'h33);
        send_pixel(1'b0, 12'd0, 12'd0, 8'h44, 8'h55, 8'h66);
        send_pixel(1'b0, 12'd0, 12'd0, 8'h77, 8'h88, 8'h99);
        send_pixel(1'b0, 12'd0, 12'd0, 8'hAA, 8'hBB, 8'hCC);
        send_pixel(1'b0, 12'd0, 12'd0, 8'hDD, 8'hEE, 8'hFF);
        send_pixel(1'b0, 12'd0, 12'd0, 8'h12, 8'h34, 8'h56);
        send_pixel(1'b0, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF);
        drain_writes();
        pixels_sent = 24;

        run_random_phase(1'b1);
        while (pixels_sent < 1650) run_random_phase(1'b0);

        if (fail_count == 0 && writes_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
